>>> design/n2a_pkg.sv
// Shared types, format codes and the hex digit table for the number formatter.
// No dependencies; imported by every module of the block.
package n2a_pkg;

	localparam int NUM_W   = 64;
	localparam int CMD_W   = 2;
	localparam int CHAR_W  = 7;
	localparam int NIB_W   = 4;
	localparam int IDX_W   = 4;   // index of a digit, up to 16 digits
	localparam int BIN_W   = 32;  // width of the decimal source value
	localparam int DEC_DIG = 10;  // decimal digits of a 32-bit value
	localparam int BCD_W   = DEC_DIG * NIB_W;
	localparam int STEP_W  = 5;   // counts the BIN_W shift steps

	localparam logic [CMD_W-1:0] CMD_HEX8  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_HEX32 = 2'd1;
	localparam logic [CMD_W-1:0] CMD_HEX64 = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DEC32 = 2'd3;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_X     = 7'h78;
	localparam logic [CHAR_W-1:0] ASCII_ALPHA = 7'h37; // 'A' - 10

	// Work handed from the front to the back: digits, index of the
	// most significant digit to send, and whether "0x" goes first.
	typedef struct packed {
		logic             prefix;
		logic [IDX_W-1:0] top;
		logic [NUM_W-1:0] digits;
	} n2a_job_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
		logic [CHAR_W-1:0] ext;
		ext = {3'b000, nib};
		return (nib > 4'd9) ? ext + ASCII_ALPHA : ext + ASCII_ZERO;
	endfunction

endpackage

>>> design/n2a_front.sv
// Front end: accepts a number and a format command, runs the binary to BCD
// conversion for decimal, and hands a digit job to the queue. Uses n2a_pkg.
module n2a_front
	import n2a_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] cmd,
	input  logic [NUM_W-1:0] number,
	output logic             job_valid,
	input  logic             job_ready,
	output n2a_job_t         job
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0]        state_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [NUM_W-1:0]  val_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [STEP_W-1:0] step_q;
	logic [BCD_W-1:0]  bcd_adj;
	logic [IDX_W-1:0]  dec_top;

	assign in_ready  = (state_q == ST_IDLE);
	assign job_valid = (state_q == ST_PUSH);

	// Add 3 to every BCD digit of 5 or more before the shift.
	always_comb begin
		for (int i = 0; i < DEC_DIG; i++) begin
			bcd_adj[i*NIB_W +: NIB_W] = (bcd_q[i*NIB_W +: NIB_W] >= 4'd5) ?
				bcd_q[i*NIB_W +: NIB_W] + 4'd3 : bcd_q[i*NIB_W +: NIB_W];
		end
	end

	// Highest nonzero decimal digit; zero still sends one digit.
	always_comb begin
		dec_top = '0;
		for (int i = 0; i < DEC_DIG; i++) begin
			if (bcd_q[i*NIB_W +: NIB_W] != '0)
				dec_top = IDX_W'(i);
		end
	end

	always_comb begin
		job = '0;
		unique case (cmd_q)
			CMD_HEX8: begin
				job.top    = IDX_W'(1);
				job.digits = val_q;
			end
			CMD_HEX32: begin
				job.prefix = 1'b1;
				job.top    = IDX_W'(7);
				job.digits = val_q;
			end
			CMD_HEX64: begin
				job.prefix = 1'b1;
				job.top    = IDX_W'(15);
				job.digits = val_q;
			end
			CMD_DEC32: begin
				job.top    = dec_top;
				job.digits = {{(NUM_W-BCD_W){1'b0}}, bcd_q};
			end
			default: job = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= (cmd == CMD_DEC32) ? ST_CONV : ST_PUSH;
				ST_CONV: if (step_q == STEP_W'(BIN_W-1)) state_q <= ST_PUSH;
				ST_PUSH: if (job_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q  <= cmd;
			step_q <= '0;
			bcd_q  <= '0;
			case (cmd)
				CMD_HEX8:  val_q <= {{(NUM_W-8){1'b0}}, number[7:0]};
				CMD_HEX64: val_q <= number;
				default:   val_q <= {{(NUM_W-BIN_W){1'b0}}, number[BIN_W-1:0]};
			endcase
		end else if (state_q == ST_CONV) begin
			// shift the binary value into the adjusted BCD register
			bcd_q  <= {bcd_adj[BCD_W-2:0], val_q[BIN_W-1]};
			val_q  <= {val_q[NUM_W-1:BIN_W], val_q[BIN_W-2:0], 1'b0};
			step_q <= step_q + STEP_W'(1);
		end
	end

endmodule

>>> design/n2a_queue.sv
// Two-entry job queue between the front and back ends.
// Uses n2a_pkg for the job type.
module n2a_queue
	import n2a_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	output logic     wr_ready,
	input  n2a_job_t wr_job,
	output logic     rd_valid,
	input  logic     rd_ready,
	output n2a_job_t rd_job
);

	n2a_job_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign wr_ready = (fill_q != 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign rd_job   = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

>>> design/n2a_back.sv
// Back end: takes a digit job from the queue and sends its characters, prefix
// first, through a registered output. Uses n2a_pkg.
module n2a_back
	import n2a_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  n2a_job_t          job,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] character,
	output logic              last
);

	logic              busy_q;
	logic [1:0]        pre_q;   // prefix characters still to send
	logic [IDX_W-1:0]  idx_q;
	logic [NUM_W-1:0]  digits_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              slot_free;
	logic              emit;
	logic [NIB_W-1:0]  nib;
	logic [CHAR_W-1:0] next_char;
	logic              next_last;

	assign slot_free = !out_valid_q || out_ready;
	assign emit      = busy_q && slot_free;
	assign job_ready = !busy_q;
	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	assign nib = NIB_W'(digits_q >> {idx_q, 2'b00});

	always_comb begin
		case (pre_q)
			2'd2:    next_char = ASCII_ZERO;
			2'd1:    next_char = ASCII_X;
			default: next_char = hex_char(nib);
		endcase
		next_last = (pre_q == 2'd0) && (idx_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!busy_q && job_valid)
				busy_q <= 1'b1;
			else if (emit && next_last)
				busy_q <= 1'b0;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && job_valid) begin
			pre_q    <= job.prefix ? 2'd2 : 2'd0;
			idx_q    <= job.top;
			digits_q <= job.digits;
		end else if (emit) begin
			// advance through the prefix, then down the digits
			if (pre_q != 2'd0)
				pre_q <= pre_q - 2'd1;
			else if (idx_q != '0)
				idx_q <= idx_q - IDX_W'(1);
		end
		if (emit) begin
			char_q <= next_char;
			last_q <= next_last;
		end
	end

endmodule

>>> design/number_to_ascii_formatter.sv
// Formats an unsigned number as ASCII characters, most significant first, with
// last set on the final one: hex8 sends 2 characters, hex32 "0x" and 8 digits,
// hex64 "0x" and 16 digits, decimal 1 to 10 digits with no leading zeros. The
// back end sends one character per cycle while the sink is ready, and goes
// idle while it loads each number from the queue. A hex number goes from idle
// straight to the push state in the front end; a decimal number first runs
// through the 32-step shift-and-add-3 BCD converter. A two-entry queue lets the
// front end convert the next number while the back end is still sending.
// Uses n2a_pkg, n2a_front, n2a_queue and n2a_back.
module number_to_ascii_formatter
	import n2a_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [NUM_W-1:0]  number,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] character,
	output logic              last
);

	n2a_job_t fr_job;
	n2a_job_t bk_job;
	logic     fr_valid;
	logic     fr_ready;
	logic     bk_valid;
	logic     bk_ready;

	n2a_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.number    (number),
		.job_valid (fr_valid),
		.job_ready (fr_ready),
		.job       (fr_job)
	);

	n2a_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_job   (fr_job),
		.rd_valid (bk_valid),
		.rd_ready (bk_ready),
		.rd_job   (bk_job)
	);

	n2a_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bk_valid),
		.job_ready (bk_ready),
		.job       (bk_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.last      (last)
	);

endmodule

>>> verif/number_to_ascii_formatter_tb.sv
// Self-checking testbench for number_to_ascii_formatter: all four formats with random gaps
// on the number side and random stalls on the character side.
// Depends on n2a_pkg and the number_to_ascii_formatter RTL.
module number_to_ascii_formatter_tb
	import n2a_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_NUMBERS = 100;
	localparam int STEADY_FROM    = 75;
	localparam int DRAIN_CYCLES   = 50;

	typedef struct {
		logic [CHAR_W-1:0] code;
		logic              fin;
	} char_beat_t;

	class ascii_scoreboard;
		char_beat_t  pending[$];
		int unsigned errors;
		int unsigned numbers_seen;
		int unsigned chars_checked;

		function void push_char(input logic [7:0] code, input logic fin);
			char_beat_t beat;
			beat.code = code[CHAR_W-1:0];
			beat.fin  = fin;
			pending.push_back(beat);
		endfunction

		function void push_hex(input logic [NUM_W-1:0] value, input int ndig, input bit prefix);
			logic [3:0] nib;
			if (prefix) begin
				push_char("0", 1'b0);
				push_char("x", 1'b0);
			end
			for (int i = 0; i < ndig; i++) begin
				nib = 4'(value >> ((ndig - 1 - i) * 4));
				push_char((nib > 4'd9) ? 8'h41 + {4'b0, nib} - 8'd10 : 8'h30 + {4'b0, nib},
					i == ndig - 1);
			end
		endfunction

		// Work out every character that one accepted number must produce.
		function void note_number(input logic [CMD_W-1:0] fmt, input logic [NUM_W-1:0] value);
			logic [31:0] rest;
			logic [3:0]  digs[10];
			int          ndig;
			numbers_seen++;
			case (fmt)
				CMD_HEX8:  push_hex({56'b0, value[7:0]}, 2, 1'b0);
				CMD_HEX32: push_hex({32'b0, value[31:0]}, 8, 1'b1);
				CMD_HEX64: push_hex(value, 16, 1'b1);
				default: begin
					// collect digits least significant first, then send them reversed
					rest = value[31:0];
					ndig = 0;
					do begin
						digs[ndig] = 4'(rest % 10);
						rest = rest / 10;
						ndig++;
					end while (rest != 0);
					for (int i = ndig - 1; i >= 0; i--)
						push_char(8'h30 + {4'b0, digs[i]}, i == 0);
				end
			endcase
		endfunction

		function void check_char(input logic [CHAR_W-1:0] code, input logic fin);
			char_beat_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat: character %h last %b with nothing pending",
					$time, code, fin);
				errors++;
				return;
			end
			want = pending.pop_front();
			chars_checked++;
			if (code !== want.code) begin
				$display("%0t: character mismatch: expected %h actual %h", $time, want.code, code);
				errors++;
			end
			if (fin !== want.fin) begin
				$display("%0t: last mismatch: expected %b actual %b", $time, want.fin, fin);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [CMD_W-1:0]  cmd;
	logic [NUM_W-1:0]  number;
	logic              out_valid;
	logic              out_ready;
	logic [CHAR_W-1:0] character;
	logic              last;

	ascii_scoreboard sb;
	bit              steady;
	int unsigned     quiet_cycles;

	number_to_ascii_formatter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.number    (number),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Inputs are noted before outputs are checked, so same-edge ordering cannot matter.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			if (in_valid && in_ready)
				sb.note_number(cmd, number);
			if (out_valid && out_ready)
				sb.check_char(character, last);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: timeout, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Sink side: random stall bursts until the steady tail of the run.
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		out_ready <= 1'b1;
		forever begin
			if (!steady && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_ready <= 1'b1;
			end
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	task automatic send_number(input logic [CMD_W-1:0] fmt, input logic [NUM_W-1:0] value);
		if (!steady && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= fmt;
		number   <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [NUM_W-1:0] pick_number();
		logic [NUM_W-1:0] v;
		logic [31:0]      p;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: ;
			1: v[31:0] = $urandom_range(0, 20);
			2: begin
				// land on or just below a power of ten to move the digit count
				p = 1;
				repeat ($urandom_range(1, 9)) p = p * 10;
				v[31:0] = p - $urandom_range(0, 1);
			end
			default: v[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 3);
		endcase
		return v;
	endfunction

	initial begin
		sb = new();
		steady = 1'b0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		cmd       <= CMD_HEX8;
		number    <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_number(CMD_HEX8, 64'h0);
		send_number(CMD_HEX8, 64'hFF);
		send_number(CMD_HEX8, 64'hDEAD_BEEF_1234_56A5);
		send_number(CMD_HEX32, 64'h0);
		send_number(CMD_HEX32, 64'hFFFF_FFFF);
		send_number(CMD_HEX32, 64'h5A5A_0000_89AB_CDEF);
		send_number(CMD_HEX64, 64'h0);
		send_number(CMD_HEX64, 64'hFFFF_FFFF_FFFF_FFFF);
		send_number(CMD_HEX64, 64'h0123_4567_89AB_CDEF);
		send_number(CMD_HEX64, 64'hFEDC_BA98_7654_3210);
		send_number(CMD_DEC32, 64'h0);
		send_number(CMD_DEC32, 64'hFFFF_FFFF_0000_0000);
		send_number(CMD_DEC32, 64'd1);
		send_number(CMD_DEC32, 64'd9);
		send_number(CMD_DEC32, 64'd10);
		send_number(CMD_DEC32, 64'd99);
		send_number(CMD_DEC32, 64'd100);
		send_number(CMD_DEC32, 64'd999_999_999);
		send_number(CMD_DEC32, 64'd1_000_000_000);
		send_number(CMD_DEC32, 64'hFFFF_FFFF);
		send_number(CMD_DEC32, 64'h1234_5678_0000_000A);

		for (int n = 0; n < RANDOM_NUMBERS; n++) begin
			if (n == STEADY_FROM)
				steady = 1'b1;
			send_number(CMD_W'($urandom_range(0, 3)), pick_number());
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d numbers in hex8, hex32, hex64 and decimal, %0d characters checked,",
			sb.numbers_seen, sb.chars_checked);
		$display("with random gaps and sink stalls, then a stall-free tail.");
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
